/* src/rlan_pkg.sv */
package rlan_pkg;

    localparam int WINDOW_DEPTH_DEF = 1024;
    localparam int SAMPLE_BITS_DEF  = 16;

    localparam int WLEN_BITS  = 11;
    localparam int COEF_BITS  = 16;
    localparam int LEVEL_BITS = 16;

    localparam logic [1:0] REG_WINDOW_LEN = 2'd0;
    localparam logic [1:0] REG_DECAY      = 2'd1;
    localparam logic [1:0] REG_THRESHOLD  = 2'd2;

    localparam logic [WLEN_BITS-1:0] WINDOW_LEN_RST = 11'd1024;
    localparam logic [COEF_BITS-1:0] DECAY_RST      = 16'd328;
    localparam logic [COEF_BITS-1:0] THRESHOLD_RST  = 16'd3277;

    localparam logic ACTION_PUSH   = 1'b0;
    localparam logic ACTION_UPDATE = 1'b1;

    typedef struct packed {
        logic clear_step;
        logic push;
        logic acc_start;
        logic acc_step;
        logic div_start;
        logic div_step;
        logic sqrt_start;
        logic sqrt_step;
        logic track;
        logic nrm_start;
        logic nrm_step;
        logic finish;
    } rlan_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic acc_done;
        logic iter_done;
    } rlan_sts_t;

endpackage

/* src/rlan_ctrl.sv */
module rlan_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic              in_action,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  rlan_pkg::rlan_sts_t sts,
    output rlan_pkg::rlan_cmd_t cmd
);
    import rlan_pkg::*;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_ACC   = 4'd2;
    localparam logic [3:0] ST_DIVS  = 4'd3;
    localparam logic [3:0] ST_DIV   = 4'd4;
    localparam logic [3:0] ST_SQS   = 4'd5;
    localparam logic [3:0] ST_SQ    = 4'd6;
    localparam logic [3:0] ST_TRACK = 4'd7;
    localparam logic [3:0] ST_NRMS  = 4'd8;
    localparam logic [3:0] ST_NRM   = 4'd9;
    localparam logic [3:0] ST_OUT   = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       accept;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign accept    = in_valid && in_ready;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (sts.clear_done) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    if (in_action == ACTION_PUSH) begin
                        cmd.push = 1'b1;
                    end else begin
                        cmd.acc_start = 1'b1;
                        state_next = ST_ACC;
                    end
                end
            end
            ST_ACC: begin
                cmd.acc_step = 1'b1;
                if (sts.acc_done) state_next = ST_DIVS;
            end
            ST_DIVS: begin
                cmd.div_start = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.iter_done) state_next = ST_SQS;
            end
            ST_SQS: begin
                cmd.sqrt_start = 1'b1;
                state_next = ST_SQ;
            end
            ST_SQ: begin
                cmd.sqrt_step = 1'b1;
                if (sts.iter_done) state_next = ST_TRACK;
            end
            ST_TRACK: begin
                cmd.track = 1'b1;
                state_next = ST_NRMS;
            end
            ST_NRMS: begin
                cmd.nrm_start = 1'b1;
                state_next = ST_NRM;
            end
            ST_NRM: begin
                cmd.nrm_step = 1'b1;
                if (sts.iter_done) begin
                    cmd.finish = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_CLEAR;
        else          state_reg <= state_next;
    end

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !in_ready)
        else $error("input accepted while busy");
    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped");
    a_update_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && in_action == ACTION_UPDATE) |=> (state_reg == ST_ACC))
        else $error("update did not start accumulation");
endmodule

/* src/rlan_dp.sv */
module rlan_dp #(
    parameter int WINDOW_DEPTH = rlan_pkg::WINDOW_DEPTH_DEF,
    parameter int SAMPLE_BITS  = rlan_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  rlan_pkg::rlan_cmd_t                 cmd,
    output rlan_pkg::rlan_sts_t                 sts,
    input  logic signed [SAMPLE_BITS-1:0]       sample,
    input  logic [rlan_pkg::WLEN_BITS-1:0]      window_len,
    input  logic [rlan_pkg::COEF_BITS-1:0]      decay_coeff,
    input  logic [rlan_pkg::COEF_BITS-1:0]      active_threshold,
    output logic [rlan_pkg::LEVEL_BITS-1:0]     rms_level,
    output logic [rlan_pkg::LEVEL_BITS-1:0]     norm_level,
    output logic                                active
);
    import rlan_pkg::*;

    localparam int AW   = $clog2(WINDOW_DEPTH);
    localparam int NW   = AW + 1;
    localparam int SQW  = 2 * SAMPLE_BITS;
    localparam int SUMW = SQW + AW;
    localparam int RW   = SQW / 2 + 1;
    localparam int LW   = LEVEL_BITS;
    localparam int NRMW = LW + 16;
    localparam int CW   = $clog2(SUMW + 1);

    logic signed [SAMPLE_BITS-1:0] ring [WINDOW_DEPTH];
    logic [AW-1:0]  wp_reg, clr_reg, rd_addr_reg;
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;
    logic [NW-1:0]  n_reg, issue_reg;
    logic [NW:0]    got_reg;
    logic           rd_vld_reg;
    logic [SQW-1:0] sq_reg;
    logic           sq_vld_reg;
    logic [SUMW-1:0] sum_reg;
    logic [SUMW-1:0] quo_reg;
    logic [NW-1:0]   rem_reg;
    logic [CW-1:0]   cnt_reg;
    logic [SQW-1:0]  rad_reg;
    logic [RW-1:0]   root_reg;
    logic [RW+1:0]   srem_reg;
    logic [LW-1:0]   floor_reg, ceil_reg, lvl_reg;
    logic [NRMW-1:0] nnum_reg;
    logic [LW:0]     nden_reg, nrem_reg;
    logic [15:0]     nq_reg;
    logic            nzero_reg, nfull_reg;
    logic [LW-1:0]   norm_reg;
    logic            act_reg;

    logic [NW-1:0] n_eff;
    always_comb begin
        if (window_len == '0)
            n_eff = NW'(1);
        else if (32'(window_len) > WINDOW_DEPTH)
            n_eff = NW'(WINDOW_DEPTH);
        else
            n_eff = NW'(window_len);
    end

    // ring addresses wrap at WINDOW_DEPTH, which need not be a power of two
    logic [AW-1:0] wp_inc, wp_dec, rd_dec;
    assign wp_inc = (32'(wp_reg) == WINDOW_DEPTH - 1) ? '0 : wp_reg + AW'(1);
    assign wp_dec = (wp_reg == '0) ? AW'(WINDOW_DEPTH - 1) : wp_reg - AW'(1);
    assign rd_dec = (rd_addr_reg == '0) ? AW'(WINDOW_DEPTH - 1) : rd_addr_reg - AW'(1);

    // ring memory: write by clear sweep or push, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.clear_step)
            ring[clr_reg] <= '0;
        else if (cmd.push)
            ring[wp_reg] <= sample;
        rd_data_reg <= ring[rd_addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
            wp_reg  <= '0;
        end else begin
            if (cmd.clear_step) clr_reg <= clr_reg + AW'(1);
            if (cmd.push)       wp_reg  <= wp_inc;
        end
    end
    assign sts.clear_done = (32'(clr_reg) == WINDOW_DEPTH - 1);

    // accumulate squares: address -> read -> square -> add
    logic signed [SQW-1:0] rd_ext;
    logic [SUMW-1:0] sum_next;
    assign rd_ext   = {{SAMPLE_BITS{rd_data_reg[SAMPLE_BITS-1]}}, rd_data_reg};
    assign sum_next = sum_reg + SUMW'(sq_reg);
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
            sq_vld_reg <= 1'b0;
        end else if (cmd.acc_start) begin
            rd_vld_reg <= 1'b0;
            sq_vld_reg <= 1'b0;
        end else if (cmd.acc_step) begin
            rd_vld_reg <= (issue_reg != '0);
            sq_vld_reg <= rd_vld_reg;
        end
        if (cmd.acc_start) begin
            n_reg       <= n_eff;
            issue_reg   <= n_eff;
            got_reg     <= '0;
            sum_reg     <= '0;
            rd_addr_reg <= wp_dec;
        end else if (cmd.acc_step) begin
            if (issue_reg != '0) begin
                issue_reg   <= issue_reg - NW'(1);
                rd_addr_reg <= rd_dec;
            end
            sq_reg <= SQW'(rd_ext * rd_ext);
            if (sq_vld_reg) begin
                sum_reg <= sum_next;
                got_reg <= got_reg + (NW+1)'(1);
            end
        end
    end
    assign sts.acc_done = cmd.acc_step && sq_vld_reg && (got_reg + (NW+1)'(1) == {1'b0, n_reg});

    // restoring divider for mean, then bit-pair square root, then normalize divide
    logic [NW:0]   dtrial;
    logic [RW+1:0] strial;
    logic [RW+1:0] stest;
    logic [LW+1:0] ntrial;
    assign dtrial = {rem_reg, quo_reg[SUMW-1]};
    assign strial = {srem_reg[RW-1:0], rad_reg[SQW-1:SQW-2]};
    assign stest  = {root_reg, 2'b01};
    assign ntrial = {nrem_reg, nnum_reg[NRMW-1]};

    logic [LW-1:0] level_w, fl_next, cl_next;
    logic [LW+COEF_BITS-1:0] fprod, cprod;
    assign level_w = LW'(root_reg);
    assign fprod = decay_coeff * (level_w - floor_reg);
    assign cprod = decay_coeff * (ceil_reg - level_w);
    always_comb begin
        fl_next = (level_w < floor_reg) ? level_w
                : floor_reg + fprod[LW+COEF_BITS-1:COEF_BITS];
        cl_next = (level_w > ceil_reg) ? level_w
                : ceil_reg - cprod[LW+COEF_BITS-1:COEF_BITS];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_reg <= '0;
            ceil_reg  <= '0;
        end else if (cmd.track) begin
            floor_reg <= fl_next;
            ceil_reg  <= cl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            quo_reg <= sum_reg;
            rem_reg <= '0;
            cnt_reg <= CW'(SUMW - 1);
        end else if (cmd.div_step) begin
            if ({1'b0, dtrial} >= {1'b0, 1'b0, n_reg}) begin
                rem_reg <= NW'(dtrial - (NW+1)'(n_reg));
                quo_reg <= {quo_reg[SUMW-2:0], 1'b1};
            end else begin
                rem_reg <= dtrial[NW-1:0];
                quo_reg <= {quo_reg[SUMW-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg - CW'(1);
        end else if (cmd.sqrt_start) begin
            rad_reg  <= SQW'(quo_reg);
            root_reg <= '0;
            srem_reg <= '0;
            cnt_reg  <= CW'(SQW / 2 - 1);
        end else if (cmd.sqrt_step) begin
            rad_reg <= {rad_reg[SQW-3:0], 2'b00};
            if (strial >= stest) begin
                srem_reg <= strial - stest;
                root_reg <= {root_reg[RW-2:0], 1'b1};
            end else begin
                srem_reg <= strial;
                root_reg <= {root_reg[RW-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg - CW'(1);
        end else if (cmd.track) begin
            lvl_reg <= level_w;
        end else if (cmd.nrm_start) begin
            nnum_reg  <= {lvl_reg - floor_reg, 16'd0};
            nden_reg  <= {1'b0, ceil_reg - floor_reg};
            nrem_reg  <= '0;
            nq_reg    <= '0;
            nzero_reg <= (ceil_reg <= floor_reg) || (lvl_reg <= floor_reg);
            nfull_reg <= (lvl_reg >= ceil_reg);
            cnt_reg   <= CW'(NRMW - 1);
        end else if (cmd.nrm_step) begin
            nnum_reg <= {nnum_reg[NRMW-2:0], 1'b0};
            if (ntrial >= {1'b0, nden_reg}) begin
                nrem_reg <= (LW+1)'(ntrial - {1'b0, nden_reg});
                nq_reg   <= {nq_reg[14:0], 1'b1};
            end else begin
                nrem_reg <= ntrial[LW:0];
                nq_reg   <= {nq_reg[14:0], 1'b0};
            end
            cnt_reg <= cnt_reg - CW'(1);
        end
    end
    assign sts.iter_done = (cnt_reg == '0);

    // quotient fits in 17 bits since level < ceiling when this path is used
    logic [16:0] nq_fin;
    logic [LW-1:0] norm_w;
    assign nq_fin = {nq_reg[15:0], (ntrial >= {1'b0, nden_reg})};
    always_comb begin
        if (nzero_reg)       norm_w = '0;
        else if (nfull_reg)  norm_w = 16'hFFFF;
        else if (nq_fin[16]) norm_w = 16'hFFFF;
        else                 norm_w = nq_fin[15:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            norm_reg <= norm_w;
            act_reg  <= (norm_w > active_threshold);
        end
    end

    assign rms_level  = lvl_reg;
    assign norm_level = norm_reg;
    assign active     = act_reg;

    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(cmd.track) |-> (floor_reg <= lvl_reg && lvl_reg <= ceil_reg))
        else $error("floor/ceiling order broken");
    a_act: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(cmd.finish) |-> (act_reg == (norm_reg > active_threshold)))
        else $error("activity flag mismatch");
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(cmd.finish) && $past(nzero_reg)) |-> (norm_reg == '0))
        else $error("norm not zero on flat range");
endmodule

/* src/rms_level_adaptive_normalizer.sv */
// RMS level meter with adaptive floor/ceiling normalization. A push transaction
// (action 0) stores one sample and produces no result. An update transaction
// (action 1) presents its result after the window is read one sample per cycle
// from the ring memory's single read port and the mean, square root and
// normalization are each formed bit-serially in a shared iterative unit.
// Input is held off until the result transaction completes. After reset the
// ring is cleared before input is taken;
// write configuration only while no update is in progress.
module rms_level_adaptive_normalizer #(
    parameter int WINDOW_DEPTH = rlan_pkg::WINDOW_DEPTH_DEF,
    parameter int SAMPLE_BITS  = rlan_pkg::SAMPLE_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [SAMPLE_BITS-1:0]      s_tdata,   // sample
    input  logic                        s_tuser,   // action
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [2*rlan_pkg::LEVEL_BITS-1:0] m_tdata, // norm_level, rms_level
    output logic                        m_tuser,   // active
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [1:0]                  cfg_index,
    input  logic [15:0]                 cfg_data
);
    import rlan_pkg::*;

    logic [WLEN_BITS-1:0] wlen_reg;
    logic [COEF_BITS-1:0] decay_reg, thr_reg;
    rlan_cmd_t cmd;
    rlan_sts_t sts;
    logic [LEVEL_BITS-1:0] rms_level, norm_level;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wlen_reg  <= WINDOW_LEN_RST;
            decay_reg <= DECAY_RST;
            thr_reg   <= THRESHOLD_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_WINDOW_LEN: wlen_reg  <= cfg_data[WLEN_BITS-1:0];
                REG_DECAY:      decay_reg <= cfg_data;
                REG_THRESHOLD:  thr_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    rlan_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_action (s_tuser),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    rlan_dp #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .sample           (s_tdata),
        .window_len       (wlen_reg),
        .decay_coeff      (decay_reg),
        .active_threshold (thr_reg),
        .rms_level        (rms_level),
        .norm_level       (norm_level),
        .active           (m_tuser)
    );

    assign m_tdata = {norm_level, rms_level};
endmodule
